// ----- rtl/core/pic_pkg.sv -----
package pic_pkg;

	localparam int unsigned HalfBits = 16;
	localparam int unsigned SrcBits  = 32;

	localparam logic [6:0] INT_VEC_BASE = 7'h40;
	localparam logic [6:0] EXT_VEC_BASE = 7'h50;

	typedef enum logic [1:0] {
		REQ_RAISE = 2'd0,
		REQ_ACK   = 2'd1,
		REQ_MASK  = 2'd2
	} req_code_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [4:0]  source_index;
		logic [15:0] mask_value;
	} req_item_t;

	typedef struct packed {
		logic [3:0] level;
		logic [6:0] vector;
	} rsp_item_t;

	typedef struct packed {
		logic       any;
		logic [3:0] level;
		logic [6:0] vector;
		logic [4:0] bit_idx;
	} winner_t;

	function automatic logic [3:0] int_level(input logic [3:0] idx);
		logic [3:0] lvl;
		case (idx)
			4'd0:  lvl = 4'hF;
			4'd1:  lvl = 4'hE;
			4'd2:  lvl = 4'hD;
			4'd3:  lvl = 4'hC;
			4'd4:  lvl = 4'hB;
			4'd5:  lvl = 4'hA;
			4'd6:  lvl = 4'h9;
			4'd7:  lvl = 4'h8;
			4'd8:  lvl = 4'h8;
			4'd9:  lvl = 4'h6;
			4'd10: lvl = 4'h6;
			4'd11: lvl = 4'h5;
			4'd12: lvl = 4'h3;
			4'd13: lvl = 4'h2;
			default: lvl = 4'h0;
		endcase
		return lvl;
	endfunction

	function automatic logic [3:0] ext_level(input logic [3:0] idx);
		logic [3:0] lvl;
		case (idx[3:2])
			2'd0:    lvl = 4'h7;
			2'd1:    lvl = 4'h4;
			default: lvl = 4'h1;
		endcase
		return lvl;
	endfunction

endpackage

// ----- rtl/core/pic_winner.sv -----
module pic_winner (
	input  logic [31:0]      pending,
	input  logic [15:0]      mask,
	output pic_pkg::winner_t win
);
	import pic_pkg::*;

	logic [HalfBits-1:0] int_live;
	logic [HalfBits-1:0] ext_live;
	logic [3:0]          int_idx;
	logic [3:0]          ext_idx;
	logic                int_found;
	logic                ext_found;
	logic [3:0]          int_lvl;
	logic [3:0]          ext_lvl;

	assign int_live = pending[HalfBits-1:0] & ~mask;
	assign ext_live = pending[SrcBits-1:HalfBits];

	// Scan from the top so the lowest set bit is the one left standing.
	always_comb begin
		int_idx   = '0;
		ext_idx   = '0;
		int_found = 1'b0;
		ext_found = 1'b0;
		for (int i = HalfBits - 1; i >= 0; i--) begin
			if (int_live[i]) begin
				int_idx   = 4'(i);
				int_found = 1'b1;
			end
			if (ext_live[i]) begin
				ext_idx   = 4'(i);
				ext_found = 1'b1;
			end
		end
	end

	assign int_lvl = int_found ? int_level(int_idx) : 4'h0;
	assign ext_lvl = ext_found ? ext_level(ext_idx) : 4'h0;

	// Internal half wins ties, including the level-0 reserved bits with no external rival.
	always_comb begin
		win.any = int_found | ext_found;
		if (!win.any) begin
			win.level   = '0;
			win.vector  = '0;
			win.bit_idx = '0;
		end else if (int_lvl >= ext_lvl) begin
			win.level   = int_lvl;
			win.vector  = INT_VEC_BASE + {3'b000, int_idx};
			win.bit_idx = {1'b0, int_idx};
		end else begin
			win.level   = ext_lvl;
			win.vector  = EXT_VEC_BASE + {3'b000, ext_idx};
			win.bit_idx = {1'b1, ext_idx};
		end
	end

endmodule

// ----- rtl/core/prioritized_interrupt_controller.sv -----
// Fixed-priority interrupt controller: 32 pending sources (16 internal, maskable; 16 external,
// never masked) and one response per request. A request raises a source, acknowledges the
// current winner, or writes the internal mask; the response gives the winner's level and
// vector (0x40+index internal, 0x50+index external, both zero when nothing is pending).
// One request is taken every cycle while responses are taken as fast; a response is
// presented once its request has passed the input register and then the result
// register, and a held response holds the request side once the input register is full.
// The pending and mask registers are read and updated between those registers, which
// sets that rate.
module prioritized_interrupt_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  pic_pkg::req_item_t  req_item,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output pic_pkg::rsp_item_t  rsp_item
);
	import pic_pkg::*;

	logic        valid_s1;
	req_item_t   item_s1;
	logic        adv_s1;
	logic [31:0] pending_q;
	logic [15:0] mask_q;
	logic [31:0] pend_upd;
	logic [15:0] mask_upd;
	logic [31:0] pend_next;
	winner_t     win;
	logic        rsp_valid_q;
	rsp_item_t   rsp_item_q;

	assign adv_s1    = valid_s1 & (~rsp_valid_q | rsp_ready);
	assign req_ready = ~valid_s1 | adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			item_s1 <= req_item;
		end
	end

	// Raise and mask write apply before the winner is picked; acknowledge picks first.
	always_comb begin
		pend_upd = pending_q;
		mask_upd = mask_q;
		if (item_s1.req_type == REQ_RAISE) begin
			pend_upd = pending_q | (32'd1 << item_s1.source_index);
		end else if (item_s1.req_type == REQ_MASK) begin
			mask_upd = item_s1.mask_value;
		end
	end

	pic_winner u_winner (
		.pending (pend_upd),
		.mask    (mask_upd),
		.win     (win)
	);

	always_comb begin
		pend_next = pend_upd;
		if (item_s1.req_type == REQ_ACK && win.any) begin
			pend_next = pend_upd & ~(32'd1 << win.bit_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= '0;
			mask_q      <= '1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				pending_q <= pend_next;
				mask_q    <= mask_upd;
			end
			if (adv_s1) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_item_q.level  <= win.level;
			rsp_item_q.vector <= win.vector;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

	a_no_clear_without_ack: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && item_s1.req_type != REQ_ACK |=>
		(pending_q & $past(pending_q)) == $past(pending_q))
		else $error("pending bit dropped without acknowledge");

	a_ack_clears_one: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && item_s1.req_type == REQ_ACK |=>
		$countones($past(pending_q) & ~pending_q) <= 1 &&
		(pending_q & ~$past(pending_q)) == 32'd0)
		else $error("acknowledge changed more than the winning bit");

	a_level_zero_vector: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_item.level == 4'h0 |->
		rsp_item.vector == 7'h00 || rsp_item.vector == 7'h4E || rsp_item.vector == 7'h4F)
		else $error("level 0 with a vector other than none or a reserved source");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> valid_s1 && rsp_valid && !rsp_ready)
		else $error("request side stalled while the pipeline can move");

endmodule

// ----- tb/prioritized_interrupt_controller_test.sv -----
module prioritized_interrupt_controller_test;
	import pic_pkg::*;

	// req_type value with no operation behind it; the block must report the winner unchanged
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	// Level per lowest pending bit of each half; entry 16 stands for an empty half.
	localparam logic [16:0][3:0] INT_LEVELS = 68'h0_0023_5668_89AB_CDEF;
	localparam logic [16:0][3:0] EXT_LEVELS = 68'h0_1111_1111_4444_7777;

	logic clk = 1'b1;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_item_t req_item = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_item_t rsp_item;

	req_item_t req_queue[$];
	rsp_item_t expected_winners[$];

	logic [31:0] irq_pending = '0;
	logic [15:0] irq_mask = 16'hFFFF;

	logic req_taken = 1'b0;
	logic rsp_taken = 1'b0;
	int unsigned req_wait = 0;
	int unsigned rsp_wait = 0;
	bit req_calm = 1'b0;
	bit rsp_calm = 1'b0;

	int unsigned req_total = 0;
	int unsigned req_count = 0;
	int unsigned rsp_count = 0;
	int unsigned raise_count = 0;
	int unsigned ack_count = 0;
	int unsigned mask_count = 0;
	int unsigned unused_count = 0;
	int unsigned live_count = 0;
	int unsigned errors = 0;

	prioritized_interrupt_controller dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_item (req_item),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_item (rsp_item)
	);

	always begin
		#1 clk = 1'b0;
		#1 clk = 1'b1;
	end

	function automatic int unsigned idle_cycles(bit calm);
		return calm ? 0 : $urandom_range(0, 18);
	endfunction

	// Apply one request to the pending/mask copy and return the winner it reports.
	function automatic rsp_item_t take_request(req_item_t r);
		logic [31:0] live;
		int unsigned ib;
		int unsigned eb;
		int unsigned hit;
		logic [3:0] il;
		logic [3:0] el;
		rsp_item_t res;
		case (r.req_type)
			REQ_RAISE: irq_pending[r.source_index] = 1'b1;
			REQ_MASK:  irq_mask = r.mask_value;
			default: ;
		endcase
		live = irq_pending & ~{16'h0000, irq_mask};
		ib = 16;
		eb = 16;
		for (int i = 15; i >= 0; i--) begin
			if (live[i])
				ib = i;
			if (live[i + 16])
				eb = i;
		end
		il = INT_LEVELS[ib];
		el = EXT_LEVELS[eb];
		res = '0;
		if (live != '0) begin
			// internal half takes ties
			if (il >= el) begin
				res.level = il;
				res.vector = INT_VEC_BASE + 7'(ib);
				hit = ib;
			end else begin
				res.level = el;
				res.vector = EXT_VEC_BASE + 7'(eb);
				hit = eb + 16;
			end
			if (r.req_type == REQ_ACK)
				irq_pending[hit] = 1'b0;
		end
		return res;
	endfunction

	task automatic queue_req(input logic [1:0] kind, input logic [4:0] idx,
			input logic [15:0] mval);
		req_item_t r;
		r.req_type = kind;
		r.source_index = idx;
		r.mask_value = mval;
		req_queue.push_back(r);
	endtask

	// Request side: hold until transfer, then wait the drawn gap before the next item.
	always @(negedge clk) begin
		if (arst_n && !(req_valid && !req_taken)) begin
			if (req_wait != 0) begin
				req_valid <= 1'b0;
				req_wait <= req_wait - 1;
			end else if (req_queue.size() != 0) begin
				if ($urandom_range(0, 29) == 0)
					req_calm = !req_calm;
				req_item <= req_queue.pop_front();
				req_valid <= 1'b1;
				req_wait <= idle_cycles(req_calm);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Response side: drop ready for the drawn stall after every transfer.
	always @(negedge clk) begin : rsp_side
		int unsigned stall;
		if (rsp_taken) begin
			if ($urandom_range(0, 29) == 0)
				rsp_calm = !rsp_calm;
			stall = idle_cycles(rsp_calm);
			rsp_wait <= stall;
			rsp_ready <= (stall == 0);
		end else if (rsp_wait != 0) begin
			rsp_wait <= rsp_wait - 1;
			rsp_ready <= (rsp_wait == 1);
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : monitor
		rsp_item_t want;
		req_taken <= arst_n && req_valid && req_ready;
		rsp_taken <= arst_n && rsp_valid && rsp_ready;
		if (arst_n && rsp_valid && rsp_ready) begin
			rsp_count++;
			if (expected_winners.size() == 0) begin
				errors++;
				$display("%0t: response with nothing outstanding: level %0d vector 0x%0h",
					$time, rsp_item.level, rsp_item.vector);
			end else begin
				want = expected_winners.pop_front();
				if (want.vector != '0)
					live_count++;
				if (rsp_item.level !== want.level) begin
					errors++;
					$display("%0t: level mismatch: expected %0d, got %0d",
						$time, want.level, rsp_item.level);
				end
				if (rsp_item.vector !== want.vector) begin
					errors++;
					$display("%0t: vector mismatch: expected 0x%0h, got 0x%0h",
						$time, want.vector, rsp_item.vector);
				end
			end
		end
		if (arst_n && req_valid && req_ready) begin
			req_count++;
			case (req_item.req_type)
				REQ_RAISE: raise_count++;
				REQ_ACK:   ack_count++;
				REQ_MASK:  mask_count++;
				default:   unused_count++;
			endcase
			expected_winners.push_back(take_request(req_item));
		end
	end

	initial begin
		int unsigned pick;
		logic [15:0] mval;
		// raises under the reset mask, unused code, ack of an external winner
		queue_req(REQ_RAISE, 5'd31, 16'hFFFF);
		queue_req(REQ_RAISE, 5'd16, 16'h0000);
		queue_req(REQ_RAISE, 5'd0, 16'hA5A5);
		queue_req(REQ_UNUSED, 5'd0, 16'h0000);
		queue_req(REQ_ACK, 5'd31, 16'hFFFF);
		// unmask everything: internal bit 0 takes over; then drain down to empty
		queue_req(REQ_MASK, 5'd0, 16'h0000);
		queue_req(REQ_ACK, 5'd0, 16'h0000);
		queue_req(REQ_ACK, 5'd0, 16'h0000);
		queue_req(REQ_ACK, 5'd0, 16'h0000);
		// reserved internal bits win with level zero
		queue_req(REQ_RAISE, 5'd14, 16'h0000);
		queue_req(REQ_RAISE, 5'd15, 16'h0000);
		queue_req(REQ_ACK, 5'd0, 16'h0000);
		queue_req(REQ_ACK, 5'd0, 16'h0000);
		// external beats a weaker internal candidate, and the other way round
		queue_req(REQ_RAISE, 5'd12, 16'h0000);
		queue_req(REQ_RAISE, 5'd20, 16'h0000);
		queue_req(REQ_RAISE, 5'd13, 16'h0000);
		queue_req(REQ_MASK, 5'd0, 16'h1000);
		queue_req(REQ_ACK, 5'd0, 16'h0000);
		queue_req(REQ_RAISE, 5'd24, 16'h0000);
		queue_req(REQ_ACK, 5'd0, 16'h0000);
		queue_req(REQ_MASK, 5'd31, 16'hFFFF);
		queue_req(REQ_ACK, 5'd0, 16'hFFFF);
		queue_req(REQ_ACK, 5'd0, 16'hFFFF);
		queue_req(REQ_UNUSED, 5'd31, 16'hFFFF);
		queue_req(REQ_MASK, 5'd0, 16'h0000);

		repeat (900) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				queue_req(REQ_RAISE, 5'($urandom), 16'($urandom));
			end else if (pick < 82) begin
				queue_req(REQ_ACK, 5'($urandom), 16'($urandom));
			end else if (pick < 96) begin
				case ($urandom_range(0, 3))
					0:       mval = 16'h0000;
					1:       mval = 16'hFFFF;
					2:       mval = 16'($urandom) & 16'($urandom);
					default: mval = 16'($urandom);
				endcase
				queue_req(REQ_MASK, 5'($urandom), mval);
			end else begin
				queue_req(REQ_UNUSED, 5'($urandom), 16'($urandom));
			end
		end
		req_total = req_queue.size();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (req_count != req_total)
			@(posedge clk);
		while (expected_winners.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("requests: %0d raise, %0d acknowledge, %0d mask write, %0d unused code",
			raise_count, ack_count, mask_count, unused_count);
		$display("responses checked: %0d, %0d of them with a pending winner",
			rsp_count, live_count);
		if (errors == 0)
			$display("prioritized_interrupt_controller_test: PASS");
		else
			$display("prioritized_interrupt_controller_test: FAIL");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("timeout waiting for requests or responses to drain");
		$display("prioritized_interrupt_controller_test: FAIL");
		$finish;
	end

endmodule
